FILE: rtl/core/phi_pkg.sv
// Package for the profile height interpolator: sizes, register codes,
// reset values, FSM states and the divider request/response words.
// No dependencies.
`timescale 1ns / 1ps

package phi_pkg;

    // Profile storage
    localparam int MAX_LEVELS = 256;
    localparam int ADDR_W     = $clog2(MAX_LEVELS);
    localparam int DATA_W     = 32;

    // Level count register and its saturation width
    localparam int NUM_W = 9;
    localparam int CNT_W = (ADDR_W + 1 > NUM_W) ? ADDR_W + 1 : NUM_W;

    // Multiply-divide unit: operands are 33-bit magnitudes
    localparam int MAG_W     = DATA_W + 1;
    localparam int REM_W     = MAG_W + 2;
    localparam int DIV_CNT_W = $clog2(MAG_W + 1);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_NUM_LEVELS   = 1'b0;
    localparam logic REG_MISSING_CODE = 1'b1;

    localparam logic [NUM_W-1:0]  NUM_LEVELS_RST   = 9'd2;
    localparam logic [DATA_W-1:0] MISSING_CODE_RST = 32'hD8F1_C000;

    // Query sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TOP  = 5'b00010,
        S_SCAN = 5'b00100,
        S_PREP = 5'b01000,
        S_DIV  = 5'b10000
    } t_state;

    // Divider request and response words
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quot;
    } t_div_rsp;

endpackage

FILE: rtl/core/phi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module phi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry; the read data is registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/phi_muldiv.sv
// Shift-subtract unit computing floor(a * num / den) for num <= den.
// Depends on phi_pkg. Each bit of a takes an add phase, then a reduce phase.
`timescale 1ns / 1ps

module phi_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  phi_pkg::t_div_req i_req,
    output phi_pkg::t_div_rsp o_rsp
);

    logic [phi_pkg::MAG_W-1:0]     r_a, n_a;
    logic [phi_pkg::REM_W-1:0]     r_n, n_n;
    logic [phi_pkg::REM_W-1:0]     r_d, n_d;
    logic [phi_pkg::REM_W-1:0]     r_d2, n_d2;
    logic [phi_pkg::REM_W-1:0]     r_r, n_r;
    logic [phi_pkg::MAG_W-1:0]     r_q, n_q;
    logic [phi_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_phase, n_phase;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;

    // Next state: add phase, then reduce phase (remainder below 3*den)
    always_comb begin
        n_a     = r_a;
        n_n     = r_n;
        n_d     = r_d;
        n_d2    = r_d2;
        n_r     = r_r;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_a     = i_req.a;
            n_n     = phi_pkg::REM_W'(i_req.num);
            n_d     = phi_pkg::REM_W'(i_req.den);
            n_d2    = phi_pkg::REM_W'(i_req.den) << 1;
            n_r     = '0;
            n_q     = '0;
            n_cnt   = phi_pkg::DIV_CNT_W'(phi_pkg::MAG_W);
            n_phase = 1'b0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            if (!r_phase) begin
                n_r     = (r_r << 1) + (r_a[phi_pkg::MAG_W-1] ? r_n : '0);
                n_q     = r_q << 1;
                n_a     = r_a << 1;
                n_phase = 1'b1;
            end else begin
                if (r_r >= r_d2) begin
                    n_r = r_r - r_d2;
                    n_q = r_q + phi_pkg::MAG_W'(2);
                end else if (r_r >= r_d) begin
                    n_r = r_r - r_d;
                    n_q = r_q + phi_pkg::MAG_W'(1);
                end
                n_phase = 1'b0;
                n_cnt   = r_cnt - phi_pkg::DIV_CNT_W'(1);
                if (r_cnt == phi_pkg::DIV_CNT_W'(1)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_n     <= n_n;
        r_d     <= n_d;
        r_d2    <= n_d2;
        r_r     <= n_r;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_phase <= n_phase;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

FILE: rtl/core/profile_height_interpolator.sv
// Top level of the profile height interpolator: config registers, profile
// RAMs, bracket scan sequencer. Depends on phi_pkg, phi_ram, phi_muldiv.
//
//   channel   signals                                   handshake
//   command   start, busy, i_mode, i_level_*, i_query_*  start && !busy
//   result    o_strobe, o_result_value, o_is_missing     o_strobe, one cycle
//   config    psel, penable, pwrite, paddr, pwdata,      APB, pready high
//             prdata, pready
//
// A load word is written when it is accepted and busy stays low. A query word
// keeps busy high through the top-level read, the bracket scan (one RAM read
// per level scanned) and, when it interpolates, the shift-subtract divider.
// The scan goes through the read address that the two profile RAMs share.
// Reset is synchronous and clears control and config; the profile RAMs hold
// garbage until loaded. The receiver cannot stall: each result shows for one
// cycle and a new command may be accepted in that same cycle.
`timescale 1ns / 1ps

module profile_height_interpolator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_mode,
    input  logic [7:0]                         i_level_index,
    input  logic signed [phi_pkg::DATA_W-1:0]  i_level_height,
    input  logic signed [phi_pkg::DATA_W-1:0]  i_level_value,
    input  logic signed [phi_pkg::DATA_W-1:0]  i_query_height,
    // result
    output logic                               o_strobe,
    output logic signed [phi_pkg::DATA_W-1:0]  o_result_value,
    output logic                               o_is_missing,
    // config
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [phi_pkg::PADDR_W-1:0]        paddr,
    input  logic [phi_pkg::PDATA_W-1:0]        pwdata,
    output logic [phi_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    // Config registers
    logic [phi_pkg::NUM_W-1:0]        r_num_levels;
    logic signed [phi_pkg::DATA_W-1:0] r_miss_code;
    logic                              w_cfg_wr;

    // Sequencer registers
    phi_pkg::t_state                   r_state, n_state;
    logic signed [phi_pkg::DATA_W-1:0] r_h, n_h;
    logic [phi_pkg::ADDR_W-1:0]        r_last, n_last;
    logic [phi_pkg::ADDR_W-1:0]        r_addr, n_addr;
    logic [phi_pkg::ADDR_W-1:0]        r_didx, n_didx;
    logic                              r_more, n_more;
    logic                              r_pend, n_pend;
    logic                              r_dtop, n_dtop;
    logic signed [phi_pkg::DATA_W-1:0] r_hprev, n_hprev;
    logic signed [phi_pkg::DATA_W-1:0] r_vprev, n_vprev;
    logic signed [phi_pkg::DATA_W-1:0] r_hb, n_hb;
    logic signed [phi_pkg::DATA_W-1:0] r_ht, n_ht;
    logic signed [phi_pkg::DATA_W-1:0] r_db, n_db;
    logic signed [phi_pkg::DATA_W-1:0] r_dt, n_dt;
    logic                              r_neg, n_neg;
    logic                              r_strobe, n_strobe;
    logic signed [phi_pkg::DATA_W-1:0] r_res, n_res;
    logic                              r_miss, n_miss;

    // Combinational helpers
    logic                              w_accept;
    logic                              w_we;
    logic [phi_pkg::ADDR_W-1:0]        w_waddr;
    logic [phi_pkg::ADDR_W-1:0]        w_raddr;
    logic signed [phi_pkg::DATA_W-1:0] w_hrd;
    logic signed [phi_pkg::DATA_W-1:0] w_vrd;
    logic [phi_pkg::CNT_W-1:0]         w_num_ext;
    logic [phi_pkg::CNT_W-1:0]         w_n_sat;
    logic signed [phi_pkg::MAG_W-1:0]  w_d;
    logic [phi_pkg::MAG_W-1:0]         w_mag;
    logic [phi_pkg::MAG_W-1:0]         w_num;
    logic [phi_pkg::MAG_W-1:0]         w_den;
    logic                              w_pair_miss;
    logic [phi_pkg::MAG_W+1:0]         w_sum;
    phi_pkg::t_div_req                 w_div_req;
    phi_pkg::t_div_rsp                 w_div_rsp;

    // Config port: write on access phase, read back by address
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels <= phi_pkg::NUM_LEVELS_RST;
            r_miss_code  <= phi_pkg::MISSING_CODE_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                phi_pkg::REG_NUM_LEVELS:   r_num_levels <= pwdata[phi_pkg::NUM_W-1:0];
                phi_pkg::REG_MISSING_CODE: r_miss_code  <= pwdata[phi_pkg::DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            phi_pkg::REG_NUM_LEVELS:   prdata = phi_pkg::PDATA_W'(r_num_levels);
            phi_pkg::REG_MISSING_CODE: prdata = phi_pkg::PDATA_W'(r_miss_code);
            default:                   prdata = '0;
        endcase
    end

    // Command accept and load write
    assign busy     = (r_state != phi_pkg::S_IDLE);
    assign w_accept = start && !busy;
    assign w_we     = w_accept && !i_mode && (int'(i_level_index) < phi_pkg::MAX_LEVELS);
    assign w_waddr  = phi_pkg::ADDR_W'(i_level_index);
    assign w_raddr  = (r_state == phi_pkg::S_TOP) ? r_last : r_addr;

    // Profile memories share one read address
    phi_ram #(
        .WIDTH (phi_pkg::DATA_W),
        .DEPTH (phi_pkg::MAX_LEVELS)
    ) u_height_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_level_height),
        .i_raddr (w_raddr),
        .o_rdata (w_hrd)
    );

    phi_ram #(
        .WIDTH (phi_pkg::DATA_W),
        .DEPTH (phi_pkg::MAX_LEVELS)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_level_value),
        .i_raddr (w_raddr),
        .o_rdata (w_vrd)
    );

    // Clamp the level count to 2..MAX_LEVELS
    assign w_num_ext = phi_pkg::CNT_W'(r_num_levels);
    assign w_n_sat   = (w_num_ext < phi_pkg::CNT_W'(2)) ? phi_pkg::CNT_W'(2) :
                       (w_num_ext > phi_pkg::CNT_W'(phi_pkg::MAX_LEVELS)) ?
                       phi_pkg::CNT_W'(phi_pkg::MAX_LEVELS) : w_num_ext;

    // Divider operands from the bracket registers
    assign w_d   = phi_pkg::MAG_W'(r_dt) - phi_pkg::MAG_W'(r_db);
    assign w_mag = w_d[phi_pkg::MAG_W-1] ? phi_pkg::MAG_W'(-w_d) : phi_pkg::MAG_W'(w_d);
    assign w_num = phi_pkg::MAG_W'(phi_pkg::MAG_W'(r_h) - phi_pkg::MAG_W'(r_hb));
    assign w_den = phi_pkg::MAG_W'(phi_pkg::MAG_W'(r_ht) - phi_pkg::MAG_W'(r_hb));
    assign w_pair_miss = (r_db == r_miss_code) || (r_dt == r_miss_code);

    assign w_div_req.start = (r_state == phi_pkg::S_PREP) && !w_pair_miss && (r_ht != r_hb);
    assign w_div_req.a     = w_mag;
    assign w_div_req.num   = w_num;
    assign w_div_req.den   = w_den;

    // Apply the signed step to the bottom value
    assign w_sum = r_neg ?
                   ((phi_pkg::MAG_W+2)'(r_db) - (phi_pkg::MAG_W+2)'(w_div_rsp.quot)) :
                   ((phi_pkg::MAG_W+2)'(r_db) + (phi_pkg::MAG_W+2)'(w_div_rsp.quot));

    phi_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Sequencer: top-level check, bracket scan, prepare, divide
    always_comb begin
        n_state  = r_state;
        n_h      = r_h;
        n_last   = r_last;
        n_addr   = r_addr;
        n_didx   = r_didx;
        n_more   = r_more;
        n_pend   = r_pend;
        n_dtop   = r_dtop;
        n_hprev  = r_hprev;
        n_vprev  = r_vprev;
        n_hb     = r_hb;
        n_ht     = r_ht;
        n_db     = r_db;
        n_dt     = r_dt;
        n_neg    = r_neg;
        n_strobe = 1'b0;
        n_res    = r_res;
        n_miss   = r_miss;
        unique case (r_state)
            phi_pkg::S_IDLE: begin
                if (w_accept && i_mode) begin
                    n_h     = i_query_height;
                    n_last  = phi_pkg::ADDR_W'(w_n_sat - phi_pkg::CNT_W'(1));
                    n_state = phi_pkg::S_TOP;
                end
            end
            phi_pkg::S_TOP: begin
                // top level read issued; start the scan from level zero
                n_addr  = '0;
                n_more  = 1'b1;
                n_pend  = 1'b1;
                n_dtop  = 1'b1;
                n_state = phi_pkg::S_SCAN;
            end
            phi_pkg::S_SCAN: begin
                // issue the next read
                if (r_more) begin
                    n_addr = r_addr + phi_pkg::ADDR_W'(1);
                    n_more = (r_addr != r_last);
                end
                n_pend = r_more;
                n_didx = r_addr;
                n_dtop = 1'b0;
                // check the word returned this cycle
                if (r_pend) begin
                    if (r_dtop) begin
                        if (r_h > w_hrd) begin
                            n_res    = r_miss_code;
                            n_miss   = 1'b1;
                            n_strobe = 1'b1;
                            n_state  = phi_pkg::S_IDLE;
                        end
                    end else begin
                        n_hprev = w_hrd;
                        n_vprev = w_vrd;
                        if (r_didx == '0) begin
                            if (r_h < w_hrd) begin
                                n_res    = r_miss_code;
                                n_miss   = 1'b1;
                                n_strobe = 1'b1;
                                n_state  = phi_pkg::S_IDLE;
                            end
                        end else if ((r_hprev <= r_h) && (w_hrd >= r_h)) begin
                            n_hb    = r_hprev;
                            n_ht    = w_hrd;
                            n_db    = r_vprev;
                            n_dt    = w_vrd;
                            n_state = phi_pkg::S_PREP;
                        end else if (r_didx == r_last) begin
                            // no bracketing pair: profile not ascending
                            n_res    = r_miss_code;
                            n_miss   = 1'b1;
                            n_strobe = 1'b1;
                            n_state  = phi_pkg::S_IDLE;
                        end
                    end
                end
            end
            phi_pkg::S_PREP: begin
                if (w_pair_miss) begin
                    n_res    = r_miss_code;
                    n_miss   = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = phi_pkg::S_IDLE;
                end else if (r_ht == r_hb) begin
                    // flat bracket: take the bottom value
                    n_res    = r_db;
                    n_miss   = 1'b0;
                    n_strobe = 1'b1;
                    n_state  = phi_pkg::S_IDLE;
                end else begin
                    n_neg   = w_d[phi_pkg::MAG_W-1];
                    n_state = phi_pkg::S_DIV;
                end
            end
            phi_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    n_res    = w_sum[phi_pkg::DATA_W-1:0];
                    n_miss   = 1'b0;
                    n_strobe = 1'b1;
                    n_state  = phi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = phi_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= phi_pkg::S_IDLE;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
            r_more   <= 1'b0;
            r_dtop   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pend   <= n_pend;
            r_more   <= n_more;
            r_dtop   <= n_dtop;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_h     <= n_h;
        r_last  <= n_last;
        r_addr  <= n_addr;
        r_didx  <= n_didx;
        r_hprev <= n_hprev;
        r_vprev <= n_vprev;
        r_hb    <= n_hb;
        r_ht    <= n_ht;
        r_db    <= n_db;
        r_dt    <= n_dt;
        r_neg   <= n_neg;
        r_res   <= n_res;
        r_miss  <= n_miss;
    end

    assign o_strobe       = r_strobe;
    assign o_result_value = r_res;
    assign o_is_missing   = r_miss;

endmodule

FILE: sim/tb_profile_height_interpolator.sv
// Testbench for profile_height_interpolator: loads level profiles, runs height
// queries and checks every result word against its own interpolation predictor.
// Depends on phi_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_profile_height_interpolator;

    localparam logic        MODE_LOAD      = 1'b0;
    localparam logic        MODE_QUERY     = 1'b1;
    localparam int unsigned ITEM_TARGET    = 1400;
    localparam int unsigned SETTLE_CYCLES  = 400;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam longint      H_MIN          = -64'sd2147483648;
    localparam longint      H_MAX          = 64'sd2147483647;

    typedef struct packed {
        logic               mode;
        logic [7:0]         idx;
        logic signed [31:0] lh;
        logic signed [31:0] lv;
        logic signed [31:0] qh;
    } prof_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               missing;
    } interp_res_t;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic                               i_mode = 1'b0;
    logic [7:0]                         i_level_index = '0;
    logic signed [phi_pkg::DATA_W-1:0]  i_level_height = '0;
    logic signed [phi_pkg::DATA_W-1:0]  i_level_value = '0;
    logic signed [phi_pkg::DATA_W-1:0]  i_query_height = '0;
    logic                               o_strobe;
    logic signed [phi_pkg::DATA_W-1:0]  o_result_value;
    logic                               o_is_missing;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [phi_pkg::PADDR_W-1:0]        paddr = '0;
    logic [phi_pkg::PDATA_W-1:0]        pwdata = '0;
    logic [phi_pkg::PDATA_W-1:0]        prdata;
    logic                               pready;

    // Predictor copy of the profile and the registers
    logic signed [31:0] lvl_height [256];
    logic signed [31:0] lvl_value  [256];
    logic [8:0]         cfg_levels  = phi_pkg::NUM_LEVELS_RST;
    logic signed [31:0] cfg_missing = phi_pkg::MISSING_CODE_RST;

    // Profile as planned by the stimulus
    logic signed [31:0] plan_h [256];
    logic signed [31:0] plan_v [256];

    prof_word_t  cmd_words [$];
    interp_res_t pending_interp [$];
    prof_word_t  nxt;
    interp_res_t want_res;
    logic        taken = 1'b0;
    int unsigned gap_left = 0;
    int unsigned calm_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned words_queued = 0;
    int unsigned fail_count = 0;

    profile_height_interpolator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_level_index  (i_level_index),
        .i_level_height (i_level_height),
        .i_level_value  (i_level_value),
        .i_query_height (i_query_height),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_is_missing   (o_is_missing),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Update the profile on a load word, predict the result of a query word
    function automatic void track_word(input prof_word_t w);
        int unsigned     n;
        int unsigned     k;
        longint          h, miss, hb, ht, db, dt, d, res;
        longint unsigned mag, num, den;
        logic [127:0]    quo;
        bit              found;
        bit              missing;
        interp_res_t     r;
        if (w.mode == MODE_LOAD) begin
            lvl_height[w.idx] = w.lh;
            lvl_value[w.idx]  = w.lv;
            return;
        end
        n = cfg_levels;
        if (n < 2) n = 2;
        if (n > 256) n = 256;
        h = w.qh;
        miss = cfg_missing;
        hb = 0; ht = 0; db = 0; dt = 0;
        found = 1'b0;
        missing = 1'b0;
        if (h > longint'(lvl_height[n-1]) || h < longint'(lvl_height[0])) begin
            missing = 1'b1;
        end else begin
            // take the first adjacent pair that brackets the height
            for (k = 0; k + 1 < n && !found; k++) begin
                if (longint'(lvl_height[k]) <= h && longint'(lvl_height[k+1]) >= h) begin
                    hb = lvl_height[k];
                    ht = lvl_height[k+1];
                    db = lvl_value[k];
                    dt = lvl_value[k+1];
                    found = 1'b1;
                end
            end
            if (!found || db == miss || dt == miss) missing = 1'b1;
        end
        if (missing) begin
            res = miss;
        end else if (ht == hb) begin
            res = db;
        end else begin
            // step toward the top value, truncated toward zero
            d   = dt - db;
            mag = (d < 0) ? -d : d;
            num = h - hb;
            den = ht - hb;
            quo = ({64'd0, mag} * {64'd0, num}) / {64'd0, den};
            res = (d < 0) ? db - longint'(quo[63:0]) : db + longint'(quo[63:0]);
        end
        r.value   = res[31:0];
        r.missing = missing;
        pending_interp.push_back(r);
    endfunction

    function automatic void push_load(input logic [7:0] idx, input logic signed [31:0] hgt,
                                      input logic signed [31:0] val);
        prof_word_t w;
        w.mode = MODE_LOAD;
        w.idx  = idx;
        w.lh   = hgt;
        w.lv   = val;
        w.qh   = $urandom;
        cmd_words.push_back(w);
        words_queued++;
    endfunction

    function automatic void push_query(input logic signed [31:0] hgt);
        prof_word_t w;
        w.mode = MODE_QUERY;
        w.idx  = $urandom_range(0, 255);
        w.lh   = $urandom;
        w.lv   = $urandom;
        w.qh   = hgt;
        cmd_words.push_back(w);
        words_queued++;
    endfunction

    // Wait until every word is taken and every result is in, then let the block settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (cmd_words.size() != 0 || start || pending_interp.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic sel, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == phi_pkg::REG_NUM_LEVELS) cfg_levels = data[8:0];
        else cfg_missing = data;
    endtask

    // Command driver: hold each word until taken, then idle for a drawn gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (start && !taken) begin
            // hold the word until the block takes it
        end else if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (cmd_words.size() != 0) begin
            nxt = cmd_words.pop_front();
            i_mode         <= nxt.mode;
            i_level_index  <= nxt.idx;
            i_level_height <= nxt.lh;
            i_level_value  <= nxt.lv;
            i_query_height <= nxt.qh;
            start          <= 1'b1;
            if (calm_left != 0) begin
                calm_left <= calm_left - 1;
                gap_left  <= 0;
            end else begin
                if ($urandom_range(0, 19) == 0) calm_left <= $urandom_range(8, 50);
                gap_left <= $urandom_range(0, 12);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // Result monitor: check each result word against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            taken        <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            taken <= start && !busy;
            if (o_strobe) begin
                if (pending_interp.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got value %0d missing %0b",
                             $time, o_result_value, o_is_missing);
                    fail_count++;
                end else begin
                    want_res = pending_interp.pop_front();
                    if (o_result_value !== want_res.value) begin
                        $display("%0t: result_value mismatch: expected %0d, got %0d",
                                 $time, want_res.value, o_result_value);
                        fail_count++;
                    end
                    if (o_is_missing !== want_res.missing) begin
                        $display("%0t: is_missing mismatch: expected %0b, got %0b",
                                 $time, want_res.missing, o_is_missing);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                track_word(prof_word_t'({i_mode, i_level_index, i_level_height,
                                         i_level_value, i_query_height}));
            end
            if ((start && !busy) || o_strobe) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        do @(posedge i_clk);
        while (quiet_cycles < WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned n_eff;
        int unsigned nq;
        int unsigned k;
        int unsigned j;
        int unsigned r;
        int unsigned shape;
        logic [8:0]  n_raw;
        longint      cur, stepmax, v, lo, hi;
        bit          backward;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Reset registers, two levels spanning the whole range, both slopes
        push_load(8'd0, 32'sh8000_0000, 32'sh8000_0000);
        push_load(8'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_query(32'sh8000_0000);
        push_query(32'sh7FFF_FFFF);
        push_query(32'sh0000_0000);
        push_query(32'shFFFF_FFFF);
        push_query(32'sh0000_0001);
        push_load(8'd0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        push_load(8'd1, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_query(32'sh0000_0000);
        push_query(32'sh0000_3039);
        wait_idle();

        // Five levels: equal bracket heights, missing bracket value, falling slope
        apb_write(phi_pkg::REG_NUM_LEVELS, 32'd5);
        push_load(8'd0, 32'sh000A_0000, 32'sh0007_0000);
        push_load(8'd1, 32'sh000A_0000, 32'shFFFD_0000);
        push_load(8'd2, 32'sh0014_0000, cfg_missing);
        push_load(8'd3, 32'sh001E_0000, 32'sd100);
        push_load(8'd4, 32'sh0028_0000, -32'sd100);
        push_query(32'sh000A_0000);
        push_query(32'sh000F_0000);
        push_query(32'sh0023_0000);
        push_query(32'sh0009_0000);
        push_query(32'sh0029_0000);

        // Random phases: new register settings, a fresh profile, then queries
        phase = 0;
        while (words_queued < ITEM_TARGET) begin
            wait_idle();
            if (phase == 6) begin
                n_raw = 9'd511;
            end else if (phase == 40) begin
                n_raw = 9'd256;
            end else begin
                r = $urandom_range(0, 9);
                if (r == 0) n_raw = $urandom_range(0, 2);
                else if (r == 1) n_raw = $urandom_range(13, 48);
                else n_raw = $urandom_range(3, 12);
            end
            n_eff = (n_raw < 2) ? 2 : ((n_raw > 256) ? 256 : n_raw);
            apb_write(phi_pkg::REG_NUM_LEVELS, {23'd0, n_raw});
            case (phase % 6)
                0: apb_write(phi_pkg::REG_MISSING_CODE, $urandom);
                2: apb_write(phi_pkg::REG_MISSING_CODE, 32'h8000_0000);
                4: apb_write(phi_pkg::REG_MISSING_CODE, 32'h7FFF_FFFF);
                5: apb_write(phi_pkg::REG_MISSING_CODE, phi_pkg::MISSING_CODE_RST);
                default: ;
            endcase

            // Build heights: dense duplicates, full span, unordered, or random climb
            shape = $urandom_range(0, 7);
            case (shape)
                0: begin
                    cur = longint'($urandom_range(0, 2097152)) - 1048576;
                    stepmax = 2;
                end
                1: begin
                    cur = H_MIN + longint'($urandom_range(0, 3));
                    stepmax = (64'sd1 <<< 32) / n_eff;
                end
                default: begin
                    cur = longint'($signed($urandom)) >>> 1;
                    stepmax = $urandom_range(1, 1 << 24);
                end
            endcase
            for (k = 0; k < n_eff; k++) begin
                if (shape == 2) begin
                    plan_h[k] = $urandom;
                end else begin
                    plan_h[k] = (cur > H_MAX) ? 32'sh7FFF_FFFF : cur[31:0];
                    if ($urandom_range(0, 5) != 0)
                        cur += longint'({$urandom, $urandom} % (stepmax + 1));
                end
                r = $urandom_range(0, 9);
                if (r == 0) plan_v[k] = cfg_missing;
                else if (r == 1) plan_v[k] = 32'sh7FFF_FFFF;
                else if (r == 2) plan_v[k] = 32'sh8000_0000;
                else if (r < 5) plan_v[k] = $urandom_range(0, 2000) - 1000;
                else plan_v[k] = $urandom;
            end
            if (shape == 1) plan_h[n_eff-1] = 32'sh7FFF_FFFF;
            backward = ($urandom_range(0, 3) == 0);
            for (k = 0; k < n_eff; k++) begin
                j = backward ? n_eff - 1 - k : k;
                push_load(j[7:0], plan_h[j], plan_v[j]);
            end

            // Query inside, at and beyond the profile, with an occasional reload
            nq = (n_eff > 64) ? $urandom_range(4, 8) : $urandom_range(6, 24);
            for (k = 0; k < nq; k++) begin
                if ($urandom_range(0, 11) == 0) begin
                    j = $urandom_range(0, 255);
                    if (j >= n_eff) plan_h[j] = $urandom;
                    plan_v[j] = $urandom_range(0, 1) ? cfg_missing : $urandom;
                    push_load(j[7:0], plan_h[j], plan_v[j]);
                end
                lo = plan_h[0];
                hi = plan_h[n_eff-1];
                r = $urandom_range(0, 9);
                case (r)
                    0: v = plan_h[$urandom_range(0, n_eff - 1)];
                    1, 2, 3, 4, 5: begin
                        if (lo <= hi) v = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
                        else v = longint'($signed($urandom));
                    end
                    6: v = lo - longint'($urandom_range(1, 1000));
                    7: v = hi + longint'($urandom_range(1, 1000));
                    8: v = $urandom_range(0, 1) ? H_MIN : H_MAX;
                    default: v = longint'($signed($urandom));
                endcase
                if (v < H_MIN) v = H_MIN;
                if (v > H_MAX) v = H_MAX;
                push_query(v[31:0]);
            end
            phase++;
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
